// File: rtl/core/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
// Depends on nothing; every other file of the block but iee_checker imports it.
`default_nettype none
package iee_pkg;

    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;
    localparam logic [1:0] ST_OVF     = 2'd3;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

    // Command that the front end hands to the back end.
    typedef enum logic [1:0] {
        CMD_PROD = 2'd0,  // close operand, then set product operator
        CMD_SUM  = 2'd1,  // close operand and term, then set sign
        CMD_END  = 2'd2   // close operand and term, then give the result
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] operand;
        logic        operand_ovf;  // operand saturated while it was built
        logic        bad_char;     // a bad character came before or with this command
        logic        bad_first;    // bad character came before operand overflow
        logic        sel;          // '/' for CMD_PROD, '-' for CMD_SUM
        logic        trail_prod;   // CMD_END from a last '*' or '/'
    } t_cmd_beat;

endpackage
`default_nettype wire

// File: rtl/core/iee_if.sv
// Valid/ready channel interfaces of the infix expression evaluator.
// Depends on iee_pkg for the internal command beat.
`default_nettype none
interface iee_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;
    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

interface iee_result_if;
    logic              valid;
    logic              ready;
    logic signed [63:0] value;
    logic [1:0]        status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

interface iee_cmd_if;
    import iee_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_beat beat;
    modport source (output valid, beat, input ready);
    modport sink   (input valid, beat, output ready);
endinterface
`default_nettype wire

// File: rtl/core/iee_front.sv
// Front end: accepts characters, builds decimal operands, issues commands.
// Depends on iee_pkg and iee_if.
`default_nettype none
module iee_front
    import iee_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    iee_char_if.sink     char_in,
    iee_cmd_if.source    cmd_out
);
    logic [31:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic        r_bad, n_bad;
    logic        r_bad_first, n_bad_first;

    logic [7:0]  c;
    logic        is_digit, is_prod, is_sum, is_space, need_cmd;
    logic [3:0]  d;
    logic [35:0] prod10;

    assign c        = char_in.char_code;
    assign is_digit = (c >= C_ZERO) && (c <= C_NINE);
    assign is_prod  = (c == C_STAR) || (c == C_SLASH);
    assign is_sum   = (c == C_PLUS) || (c == C_MINUS);
    assign is_space = (c == C_SPACE);
    assign need_cmd = is_prod || is_sum || char_in.last;
    assign d        = 4'(c - C_ZERO);
    assign prod10   = {4'd0, r_acc} * 36'd10 + {32'd0, d};

    // A character that needs a command waits for queue space.
    assign char_in.ready = !need_cmd || cmd_out.ready;
    assign cmd_out.valid = char_in.valid && need_cmd;

    // Command beat. A last '*' or '/' closes the operand as usual and marks
    // the trailing product, which the back end closes with an empty operand.
    always_comb begin
        cmd_out.beat.operand     = r_acc;
        cmd_out.beat.operand_ovf = r_ovf;
        cmd_out.beat.bad_char    = r_bad || (!is_digit && !is_prod && !is_sum
                                              && !is_space);
        cmd_out.beat.bad_first   = r_bad ? r_bad_first : 1'b0;
        cmd_out.beat.sel         = (c == C_SLASH) || (c == C_MINUS);
        cmd_out.beat.trail_prod  = char_in.last && is_prod;
        if (char_in.last) begin
            cmd_out.beat.cmd = CMD_END;
        end else if (is_prod) begin
            cmd_out.beat.cmd = CMD_PROD;
        end else begin
            cmd_out.beat.cmd = CMD_SUM;
        end
        // A digit that is also last joins the operand first.
        if (is_digit) begin
            cmd_out.beat.operand     = n_acc;
            cmd_out.beat.operand_ovf = n_ovf;
            cmd_out.beat.bad_first   = r_bad_first;
        end
        if (!r_bad && cmd_out.beat.bad_char) begin
            cmd_out.beat.bad_first = !r_ovf;
        end
    end

    // Operand and pending flags for the next character.
    always_comb begin
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_bad       = r_bad;
        n_bad_first = r_bad_first;
        if (is_digit) begin
            if (prod10[35:32] != 4'd0) begin
                n_acc = 32'hFFFF_FFFF;
                n_ovf = 1'b1;
            end else begin
                n_acc = prod10[31:0];
            end
        end else if (!is_prod && !is_sum && !is_space && !r_bad) begin
            n_bad       = 1'b1;
            n_bad_first = !r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_bad <= 1'b0;
            r_bad_first <= 1'b0;
        end else if (char_in.valid && char_in.ready) begin
            if (need_cmd) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_bad <= 1'b0;
                r_bad_first <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
                r_bad <= n_bad;
                r_bad_first <= n_bad_first;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/iee_fifo.sv
// Short command queue between front end and back end.
// Depends on iee_pkg and iee_if.
`default_nettype none
module iee_fifo
    import iee_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    iee_cmd_if.sink     wr,
    iee_cmd_if.source   rd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd_beat         r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              do_wr, do_rd;

    assign wr.ready = (r_cnt != (AW+1)'(DEPTH));
    assign rd.valid = (r_cnt != '0);
    assign rd.beat  = r_mem[r_rp];
    assign do_wr    = wr.valid && wr.ready;
    assign do_rd    = rd.valid && rd.ready;

    // Storage beats.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= wr.beat;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/iee_back.sv
// Back end: carries out commands with a bit-serial multiply/divide unit.
// Depends on iee_pkg and iee_if.
`default_nettype none
module iee_back
    import iee_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    iee_cmd_if.sink      cmd_in,
    iee_result_if.source res_out
);
    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state;
    logic signed [W-1:0] r_sum, r_term;
    logic [1:0]         r_pop;
    logic               r_sign;
    logic [1:0]         r_err;
    t_cmd_beat          r_cmd;
    // Shared serial unit: magnitude, operand, partial result, remainder.
    logic [W-1:0]       r_mag, r_acc, r_rem;
    logic [31:0]        r_k;
    logic               r_neg, r_movf;
    logic [CW-1:0]      r_cnt;
    logic               r_out_v;
    logic signed [63:0] r_out_val;
    logic [1:0]         r_out_st;

    logic [W-1:0]       limit, mag_in;
    logic [W:0]         acc_add, rem_sh, rem_sub;
    logic [W-1:0]       term_mag_done;
    logic signed [W-1:0] term_res, sum_res;
    logic [1:0]         err_res;
    logic [W+32:0]      fix;
    logic signed [W:0]  sum_wide;

    function automatic logic [1:0] flag(input logic [1:0] cur, input logic [1:0] code);
        flag = (cur == ST_OK) ? code : cur;
    endfunction

    // The result register parts the back end from the result channel.
    assign cmd_in.ready  = (r_state == S_IDLE);
    assign res_out.valid = r_out_v;
    assign res_out.value = r_out_val;
    assign res_out.status = r_out_st;

    assign mag_in  = r_term[W-1] ? W'(-r_term) : W'(r_term);
    assign limit   = r_neg ? W'(VMIN) : W'(VMAX);
    assign acc_add = {1'b0, r_acc} + {1'b0, r_mag};
    assign rem_sh  = {r_rem, r_mag[W-1]};
    assign rem_sub = rem_sh - {(W+1-32)'(0), r_k};
    assign fix     = (W+33)'(r_cmd.operand) << FRAC_BITS;
    assign term_mag_done = r_acc;

    // Closing the term into the sum, and errors in order of occurrence.
    always_comb begin
        term_res = r_term;
        err_res  = r_err;
        if (r_cmd.bad_char && r_cmd.bad_first) err_res = flag(err_res, ST_BADCHAR);
        if (r_cmd.operand_ovf) err_res = flag(err_res, ST_OVF);
        if (r_cmd.bad_char && !r_cmd.bad_first) err_res = flag(err_res, ST_BADCHAR);
        unique case (r_pop)
            OP_MUL: begin
                if (r_movf) begin
                    err_res  = flag(err_res, ST_OVF);
                    term_res = r_neg ? VMIN : VMAX;
                end else begin
                    term_res = r_neg ? -$signed(term_mag_done) : $signed(term_mag_done);
                end
            end
            OP_DIV: begin
                if (r_cmd.operand == 32'd0) begin
                    err_res  = flag(err_res, ST_DIV0);
                    term_res = '0;
                end else begin
                    term_res = r_neg ? -$signed(term_mag_done) : $signed(term_mag_done);
                end
            end
            default: begin
                if (fix > (W+33)'(VMAX)) begin
                    err_res  = flag(err_res, ST_OVF);
                    term_res = VMAX;
                end else begin
                    term_res = W'(fix);
                end
            end
        endcase
        sum_wide = r_sign ? ({r_sum[W-1], r_sum} - {term_res[W-1], term_res})
                          : ({r_sum[W-1], r_sum} + {term_res[W-1], term_res});
        if (sum_wide[W] != sum_wide[W-1]) begin
            sum_res = sum_wide[W] ? VMIN : VMAX;
        end else begin
            sum_res = sum_wide[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_term  <= '0;
            r_pop   <= OP_NONE;
            r_sign  <= 1'b0;
            r_err   <= ST_OK;
            r_out_v <= 1'b0;
        end else begin
            if (res_out.valid && res_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_in.valid && cmd_in.ready) begin
                        r_cmd  <= cmd_in.beat;
                        r_mag  <= mag_in;
                        r_neg  <= r_term[W-1];
                        r_k    <= cmd_in.beat.operand;
                        r_acc  <= '0;
                        r_rem  <= '0;
                        r_movf <= 1'b0;
                        r_cnt  <= '0;
                        if (r_pop == OP_MUL) begin
                            r_state <= S_MUL;
                        end else if (r_pop == OP_DIV && cmd_in.beat.operand != 0) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                // Shift-add multiply, one multiplier bit a cycle.
                S_MUL: begin
                    if (r_k[0]) begin
                        if (acc_add > {1'b0, limit}) r_movf <= 1'b1;
                        r_acc <= acc_add[W-1:0];
                    end
                    if (r_k[31:1] != 31'd0 && r_mag[W-1]) r_movf <= 1'b1;
                    r_mag <= r_mag << 1;
                    r_k   <= r_k >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(31)) r_state <= S_APPLY;
                end
                // Restoring divide, one quotient bit a cycle.
                S_DIV: begin
                    if (!rem_sub[W]) begin
                        r_rem <= rem_sub[W-1:0];
                    end else begin
                        r_rem <= rem_sh[W-1:0];
                    end
                    r_acc <= {r_acc[W-2:0], !rem_sub[W]};
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W-1)) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_cmd.cmd == CMD_PROD) begin
                        r_term  <= term_res;
                        r_err   <= err_res;
                        r_pop   <= r_cmd.sel ? OP_DIV : OP_MUL;
                        r_state <= S_IDLE;
                    end else begin
                        // A trailing product meets an empty operand: the term
                        // becomes zero, and a trailing divide flags it.
                        if (r_cmd.trail_prod) begin
                            r_err <= flag(err_res, r_cmd.sel ? ST_DIV0 : ST_OK);
                        end else begin
                            r_err <= flag(err_res, (sum_wide[W] != sum_wide[W-1])
                                          ? ST_OVF : ST_OK);
                            r_sum <= sum_res;
                        end
                        r_term  <= '0;
                        r_pop   <= OP_NONE;
                        r_sign  <= r_cmd.sel;
                        r_state <= (r_cmd.cmd == CMD_END) ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_out_v) begin
                        r_out_v   <= 1'b1;
                        r_out_val <= 64'(r_sum);
                        r_out_st  <= r_err;
                        r_sum  <= '0;
                        r_sign <= 1'b0;
                        r_err  <= ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/infix_expression_evaluator_top.sv
// One character beat is taken per cycle; an operator or the last character
// also needs a free slot in the four-entry command queue.
// The back end takes one command at a time; closing a multiply steps through
// the 32 operand bits and closing a divide through VALUE_WIDTH quotient bits.
// The last character's command passes the queue, S_IDLE, any S_MUL or S_DIV
// steps, S_APPLY and S_OUT, which waits while an earlier result is unread.
// Synchronous active-low reset clears the control state, empties the queue and drops the result valid.
`default_nettype none
module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    iee_char_if.sink     i_char,
    iee_result_if.source o_result
);
    iee_cmd_if cmd_q ();
    iee_cmd_if cmd_b ();

    iee_front u_front (.i_clk, .i_rst_n, .char_in(i_char), .cmd_out(cmd_q));
    iee_fifo #(.DEPTH(4)) u_fifo (.i_clk, .i_rst_n, .wr(cmd_q), .rd(cmd_b));
    iee_back #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n, .cmd_in(cmd_b), .res_out(o_result));
endmodule
`default_nettype wire

// File: rtl/core/iee_checker.sv
// Port-level checks of the infix expression evaluator.
// Depends only on the top level's result ports; bound to the top level.
`default_nettype none
module iee_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        res_valid,
    input wire        res_ready,
    input wire [63:0] res_value,
    input wire [1:0]  res_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value)
                                    && $stable(res_status))
        else $error("result beat dropped or changed");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !res_valid)
        else $error("result valid after reset");
    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(res_valid))
        else $error("result valid unknown");
    a_data_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !$isunknown({res_value, res_status}))
        else $error("result beat carries unknown bits");
endmodule

bind infix_expression_evaluator_top iee_checker u_chk (
    .i_clk, .i_rst_n, .res_valid(o_result.valid), .res_ready(o_result.ready),
    .res_value(o_result.value), .res_status(o_result.status));
`default_nettype wire
